// ===== src/aesctr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_pkg
// Shared constants, types and byte-level functions of the AES-128 CTR unit.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    // register indexes
    localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
    localparam logic [1:0] REG_KEY_LOW     = 2'd1;
    localparam logic [1:0] REG_NONCE_WORD  = 2'd2;
    localparam logic [1:0] REG_COUNT_START = 2'd3;

    // operation codes
    localparam logic OP_CTR = 1'b0;
    localparam logic OP_RAW = 1'b1;

    localparam int NUM_ROUNDS = 10;

    typedef logic [127:0] t_block;

    // round key request from the control side to the key schedule
    typedef struct packed {
        logic       expand;
        logic [3:0] round;
    } t_key_req;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] n);
        logic [7:0] r;
        case (n)
            4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
            4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
            4'd9: r = 8'h1b; 4'd10: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ===== src/aes128_ctr_cipher_unit.sv =====
`timescale 1ns / 1ps
// the input word passes the key add and ten rounds before the output word is registered
// no new word is taken until the last result is accepted; one shared round unit
// a key register write expands the schedule, input held off while it runs
// reset: synchronous active low; keys, nonce and count clear to zero
// ----------------------------------------------------------------------------
// aes128_ctr_cipher_unit
// AES-128 encrypt with CTR keystream xor and raw block mode, APB config.
// ----------------------------------------------------------------------------
module aes128_ctr_cipher_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // data_high[63:0], data_low[127:64], byte_count[132:128], zero fill
    input  logic [135:0] s_tdata,
    // op
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_high[63:0], result_low[127:64], count_used[191:128]
    output logic [191:0] m_tdata
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [63:0]  r_key_high, r_key_low, r_nonce, r_count;
    logic [1:0]   r_state;
    logic [3:0]   r_round;
    logic [127:0] r_state_blk, r_data;
    logic [4:0]   r_bytes;
    logic         r_op;
    logic [191:0] r_out;
    logic         w_wr, w_busy;
    logic [1:0]   w_idx;
    logic [127:0] w_rk, w_sub, w_mix, w_ks, w_res;
    aesctr_pkg::t_key_req w_req;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:3];

    // register read back
    always_comb begin
        unique case (w_idx)
            aesctr_pkg::REG_KEY_HIGH:   prdata = r_key_high;
            aesctr_pkg::REG_KEY_LOW:    prdata = r_key_low;
            aesctr_pkg::REG_NONCE_WORD: prdata = r_nonce;
            default:                    prdata = r_count;
        endcase
    end

    assign w_req.expand = w_wr && (w_idx == aesctr_pkg::REG_KEY_HIGH ||
                                   w_idx == aesctr_pkg::REG_KEY_LOW);
    assign w_req.round  = (r_state == ST_RUN) ? r_round : 4'd0;

    aesctr_key_sched u_ks (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_key       ((w_idx == aesctr_pkg::REG_KEY_HIGH) ? {pwdata, r_key_low}
                                                            : {r_key_high, pwdata}),
        .o_busy      (w_busy),
        .o_round_key (w_rk)
    );

    // shared round unit: subbytes and shiftrows, then mixcolumns
    always_comb begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                w_sub[127 - 8*(r + 4*c) -: 8] =
                    aesctr_pkg::sbox(r_state_blk[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = w_sub[127 - 32*c -: 8];
            a1 = w_sub[119 - 32*c -: 8];
            a2 = w_sub[111 - 32*c -: 8];
            a3 = w_sub[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            w_mix[127 - 32*c -: 8] = a0 ^ al ^ aesctr_pkg::xtime(a0 ^ a1);
            w_mix[119 - 32*c -: 8] = a1 ^ al ^ aesctr_pkg::xtime(a1 ^ a2);
            w_mix[111 - 32*c -: 8] = a2 ^ al ^ aesctr_pkg::xtime(a2 ^ a3);
            w_mix[103 - 32*c -: 8] = a3 ^ al ^ aesctr_pkg::xtime(a3 ^ a0);
        end
    end

    // final round result: raw block, or keystream xor data masked to the byte count
    assign w_ks = w_sub ^ w_rk;
    always_comb begin
        for (int i = 0; i < 16; i++)
            w_res[127 - 8*i -: 8] = (r_op == aesctr_pkg::OP_RAW) ? w_ks[127 - 8*i -: 8] :
                ((5'(i) < r_bytes) ? (w_ks[127 - 8*i -: 8] ^ r_data[127 - 8*i -: 8])
                                   : 8'h00);
    end

    assign s_tready = (r_state == ST_IDLE) && !w_busy;
    assign m_tvalid = (r_state == ST_OUT);
    assign m_tdata  = r_out;

    // config registers and round sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_nonce    <= '0;
            r_count    <= '0;
            r_state    <= ST_IDLE;
            r_round    <= 4'd0;
        end else begin
            if (w_wr) begin
                unique case (w_idx)
                    aesctr_pkg::REG_KEY_HIGH:   r_key_high <= pwdata;
                    aesctr_pkg::REG_KEY_LOW:    r_key_low  <= pwdata;
                    aesctr_pkg::REG_NONCE_WORD: r_nonce    <= pwdata;
                    default:                    r_count    <= pwdata;
                endcase
            end
            unique case (r_state)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    r_op    <= s_tuser;
                    r_data  <= {s_tdata[63:0], s_tdata[127:64]};
                    r_bytes <= (s_tdata[132:128] > 5'd16) ? 5'd16 : s_tdata[132:128];
                    r_state_blk <= (s_tuser == aesctr_pkg::OP_RAW)
                                   ? {s_tdata[63:0], s_tdata[127:64]}
                                   : {r_nonce, r_count};
                    r_round <= 4'd0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (r_round == 4'd0) r_state_blk <= r_state_blk ^ w_rk;
                    else r_state_blk <= w_mix ^ w_rk;
                    r_round <= r_round + 4'd1;
                    if (r_round == 4'(aesctr_pkg::NUM_ROUNDS)) begin
                        r_out[63:0]    <= w_res[127:64];
                        r_out[127:64]  <= w_res[63:0];
                        r_out[191:128] <= (r_op == aesctr_pkg::OP_RAW) ? 64'd0 : r_count;
                        if (r_op == aesctr_pkg::OP_CTR) r_count <= r_count + 64'd1;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: if (m_tready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== src/aesctr_key_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_key_sched
// Round key store with one key expansion step per cycle.
// ----------------------------------------------------------------------------
module aesctr_key_sched (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aesctr_pkg::t_key_req  i_req,
    input  logic [127:0]          i_key,
    output logic                  o_busy,
    output logic [127:0]          o_round_key
);
    logic [127:0] r_keys [0:10];
    logic [3:0]   r_step;
    logic         r_busy;
    logic [127:0] w_prev;
    logic [127:0] w_next;
    logic [31:0]  w_t;
    logic [3:0]   w_step_idx;

    assign o_busy      = r_busy;
    assign o_round_key = r_keys[i_req.round];
    assign w_step_idx  = r_step - 4'd1;
    assign w_prev      = r_keys[w_step_idx];

    // one schedule round: rot, sub, rcon and the xor chain
    always_comb begin
        w_t = {aesctr_pkg::sbox(w_prev[23:16]) ^ aesctr_pkg::rcon(r_step),
               aesctr_pkg::sbox(w_prev[15:8]),
               aesctr_pkg::sbox(w_prev[7:0]),
               aesctr_pkg::sbox(w_prev[31:24])};
        w_next[127:96] = w_prev[127:96] ^ w_t;
        w_next[95:64]  = w_prev[95:64]  ^ w_next[127:96];
        w_next[63:32]  = w_prev[63:32]  ^ w_next[95:64];
        w_next[31:0]   = w_prev[31:0]   ^ w_next[63:32];
    end

    // expansion sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 4'd0;
            for (int i = 0; i <= 10; i++) r_keys[i] <= '0;
        end else if (i_req.expand) begin
            r_keys[0] <= i_key;
            r_busy    <= 1'b1;
            r_step    <= 4'd1;
        end else if (r_busy) begin
            r_keys[r_step] <= w_next;
            r_step <= r_step + 4'd1;
            if (r_step == 4'(aesctr_pkg::NUM_ROUNDS)) r_busy <= 1'b0;
        end
    end
endmodule

// ===== src/aesctr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_checker
// Port-level checks of the cipher unit handshake and sequencing.
// ----------------------------------------------------------------------------
module aesctr_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);
    // output word holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out held");
    // never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !s_tready) else $error("ready with result");
    // accepted word gives no result on the next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !m_tvalid && !s_tready) else $error("latency");
    // no valid out during reset release
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid) else $error("valid after reset");
endmodule

bind aes128_ctr_cipher_unit aesctr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
